// ===== design/ir_code_filter_fifo_assert.svh =====
// Assertion macros for the infrared code filter and queue.
// Used by the top level; depends on nothing else.
`ifndef IR_CODE_FILTER_FIFO_ASSERT_SVH
`define IR_CODE_FILTER_FIFO_ASSERT_SVH
`ifndef SYNTHESIS
`define IRCF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define IRCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define IRCF_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define IRCF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/ircf_pkg.sv =====
// Shared types and constants for the infrared code filter and queue.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ircf_pkg;

    localparam int SYS_W    = 16;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [SYS_W-1:0]  SYS_CODE_RESET  = 16'hFF00;
    localparam logic [BYTE_W-1:0] THRESHOLD_RESET = 8'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_SYSTEM_CODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 1'b1;

    localparam logic FUNC_EVENT = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_READ     = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_REJECT   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_SUPPRESS = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_QUEUED   = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd4;

    typedef enum logic {
        CTRL_IDLE,
        CTRL_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic load_in;
        logic exec;
    } ircf_cmd_t;

    typedef struct packed {
        logic q_empty;
        logic q_full;
    } ircf_status_t;

endpackage

`default_nettype wire

// ===== design/ircf_ctrl.sv =====
// Controller state machine: captures a word, then executes it once the output
// register is free. Depends on ircf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ircf_ctrl
    import ircf_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    output ircf_cmd_t         cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CTRL_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.load_in = 1'b0;
        cmd.exec    = 1'b0;
        unique case (state_reg)
            CTRL_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = CTRL_EXEC;
                end
            end
            CTRL_EXEC:
            begin
                // The result may only be written once the previous one has left.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.exec   = 1'b1;
                    state_next = CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = CTRL_IDLE;
            end
        endcase

        if (cmd.exec)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== design/ircf_datapath.sv =====
// Datapath: configuration registers, captured word, frame check, repeat
// counter, ring queue store and output registers. Depends on ircf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ircf_datapath
    import ircf_pkg::*;
#(
    parameter int QUEUE_SLOTS = 10
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  func,
    input  wire logic [SYS_W-1:0]      system_code,
    input  wire logic [BYTE_W-1:0]     command_byte,
    input  wire logic [BYTE_W-1:0]     inverted_command,
    input  wire logic                  repeat_flag,
    input  wire ircf_cmd_t             cmd,
    output ircf_status_t               status,
    output logic [BYTE_W-1:0]          read_code,
    output logic                       read_valid,
    output logic [STATUS_W-1:0]        event_status
);

    localparam int IDX_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(QUEUE_SLOTS - 1);

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
        next_slot = (i == LAST_SLOT) ? '0 : i + 1'b1;
    endfunction

    logic [SYS_W-1:0]    exp_sys_reg;
    logic [BYTE_W-1:0]   threshold_reg;
    logic [IDX_W-1:0]    head_reg;
    logic [IDX_W-1:0]    head_next;
    logic [IDX_W-1:0]    tail_reg;
    logic [IDX_W-1:0]    tail_next;
    logic [BYTE_W-1:0]   rpt_count_reg;
    logic [BYTE_W-1:0]   rpt_count_next;

    logic                func_in_reg;
    logic [SYS_W-1:0]    sys_in_reg;
    logic [BYTE_W-1:0]   cmd_in_reg;
    logic [BYTE_W-1:0]   inv_in_reg;
    logic                rep_in_reg;

    logic [BYTE_W-1:0]   store [QUEUE_SLOTS];
    logic [BYTE_W-1:0]   code_reg;
    logic                valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;

    logic [IDX_W-1:0]    head_adv;
    logic [IDX_W-1:0]    tail_adv;
    logic [BYTE_W-1:0]   rpt_inc;
    logic                frame_ok;
    logic                do_pop;
    logic                do_push;

    assign head_adv = next_slot(head_reg);
    assign tail_adv = next_slot(tail_reg);
    assign rpt_inc  = rpt_count_reg + 1'b1;
    // The inverted byte must be the exact complement of the command byte.
    assign frame_ok = (sys_in_reg == exp_sys_reg) && (cmd_in_reg == ~inv_in_reg);

    assign status.q_empty = (head_reg == tail_reg);
    assign status.q_full  = (tail_adv == head_reg);

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        rpt_count_next = rpt_count_reg;
        status_next    = STATUS_READ;
        do_pop         = 1'b0;
        do_push        = 1'b0;
        if (func_in_reg == FUNC_READ)
        begin
            if (!status.q_empty)
            begin
                do_pop    = 1'b1;
                head_next = head_adv;
            end
        end
        else if (!frame_ok)
        begin
            status_next = STATUS_REJECT;
        end
        else if (rep_in_reg && (rpt_inc < threshold_reg))
        begin
            rpt_count_next = rpt_inc;
            status_next    = STATUS_SUPPRESS;
        end
        else
        begin
            rpt_count_next = '0;
            if (status.q_full)
            begin
                status_next = STATUS_FULL;
            end
            else
            begin
                do_push     = 1'b1;
                tail_next   = tail_adv;
                status_next = STATUS_QUEUED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_sys_reg   <= SYS_CODE_RESET;
            threshold_reg <= THRESHOLD_RESET;
            head_reg      <= LAST_SLOT;
            tail_reg      <= LAST_SLOT;
            rpt_count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                priority if (cfg_index == CFG_SYSTEM_CODE)
                    exp_sys_reg <= cfg_data;
                else if (cfg_index == CFG_THRESHOLD)
                    threshold_reg <= cfg_data[BYTE_W-1:0];
            end
            if (cmd.exec)
            begin
                head_reg      <= head_next;
                tail_reg      <= tail_next;
                rpt_count_reg <= rpt_count_next;
            end
        end
    end

    // Captured word, queue store and output word carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_in_reg <= func;
            sys_in_reg  <= system_code;
            cmd_in_reg  <= command_byte;
            inv_in_reg  <= inverted_command;
            rep_in_reg  <= repeat_flag;
        end
        if (cmd.exec)
        begin
            if (do_push)
                store[tail_adv] <= cmd_in_reg;
            // The store's read data register doubles as the output code register.
            code_reg   <= do_pop ? store[head_adv] : '0;
            valid_reg  <= do_pop;
            status_reg <= status_next;
        end
    end

    assign read_code    = code_reg;
    assign read_valid   = valid_reg;
    assign event_status = status_reg;

endmodule

`default_nettype wire

// ===== design/ir_code_filter_fifo.sv =====
// Top level of the infrared code filter and queue.
// Instantiates ircf_ctrl and ircf_datapath; depends on ircf_pkg and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "ir_code_filter_fifo_assert.svh"

// Checks decoded remote frames (func 0) against the configured system code and
// the command/inverse pair, filters repeats against a threshold, and queues good
// codes in a ring of QUEUE_SLOTS entries of which one is always left empty; a host
// read (func 1) pops the oldest code. Each word is first captured and then executed
// against the queue pointers and store, which is the controller's capture/execute
// sequence. A new word is taken while the previous result still waits on the
// output; execution stalls until that result has gone.
// Configuration writes take effect on the clock edge at which cfg_we is high.
module ir_code_filter_fifo
    import ircf_pkg::*;
#(
    parameter int QUEUE_SLOTS = 10
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  func,
    input  wire logic [SYS_W-1:0]      system_code,
    input  wire logic [BYTE_W-1:0]     command_byte,
    input  wire logic [BYTE_W-1:0]     inverted_command,
    input  wire logic                  repeat_flag,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [BYTE_W-1:0]          read_code,
    output logic                       read_valid,
    output logic [STATUS_W-1:0]        event_status
);

    ircf_cmd_t    cmd;
    ircf_status_t status;

    ircf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    ircf_datapath #(
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .func             (func),
        .system_code      (system_code),
        .command_byte     (command_byte),
        .inverted_command (inverted_command),
        .repeat_flag      (repeat_flag),
        .cmd              (cmd),
        .status           (status),
        .read_code        (read_code),
        .read_valid       (read_valid),
        .event_status     (event_status)
    );

    `IRCF_ASSERT_NEXT(a_exec_loads_output, clk, rst_n, cmd.exec, out_valid)
    `IRCF_ASSERT_NEXT(a_one_word_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)
    `IRCF_ASSERT_SAME(a_empty_not_full, clk, rst_n, status.q_empty, !status.q_full)
    `IRCF_ASSERT_SAME(a_pop_is_read, clk, rst_n, out_valid && read_valid, event_status == STATUS_READ)

endmodule

`default_nettype wire

// ===== sim/ircf_checker.sv =====
// Checker for the infrared code filter and queue: watches both channels and the
// register port, predicts every result word and compares it with the block.
// Depends on ircf_pkg.
`timescale 1ns / 1ps

module ircf_checker
    import ircf_pkg::*;
#(
    parameter int QUEUE_SLOTS = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic                  func,
    input  logic [SYS_W-1:0]      system_code,
    input  logic [BYTE_W-1:0]     command_byte,
    input  logic [BYTE_W-1:0]     inverted_command,
    input  logic                  repeat_flag,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [BYTE_W-1:0]     read_code,
    input  logic                  read_valid,
    input  logic [STATUS_W-1:0]   event_status,
    output int                    fail_count,
    output int                    words_due
);

    typedef struct packed {
        logic [BYTE_W-1:0]   code;
        logic                valid;
        logic [STATUS_W-1:0] status;
    } ir_result_t;

    logic [BYTE_W-1:0] key_ring [QUEUE_SLOTS];
    int                head_ptr;
    int                tail_ptr;
    logic [BYTE_W-1:0] repeat_tally;
    logic [SYS_W-1:0]  expected_sys;
    logic [BYTE_W-1:0] repeat_limit;
    ir_result_t        due_results [$];
    int                result_seq;

    function automatic int ring_next(input int i);
        return (i == QUEUE_SLOTS - 1) ? 0 : i + 1;
    endfunction

    // Applies one input word to the predicted queue state and returns its result.
    function automatic ir_result_t filter_word(input logic f, input logic [SYS_W-1:0] sys,
                                               input logic [BYTE_W-1:0] cmd,
                                               input logic [BYTE_W-1:0] inv,
                                               input logic rep);
        ir_result_t r;
        int         nt;
        logic       held;
        r.code   = '0;
        r.valid  = 1'b0;
        r.status = STATUS_READ;
        held     = 1'b0;
        if (f == FUNC_READ)
        begin
            if (head_ptr != tail_ptr)
            begin
                head_ptr = ring_next(head_ptr);
                r.code   = key_ring[head_ptr];
                r.valid  = 1'b1;
            end
        end
        else if (sys != expected_sys || cmd != ~inv)
        begin
            // A rejected frame leaves the repeat count alone.
            r.status = STATUS_REJECT;
        end
        else
        begin
            if (rep)
            begin
                repeat_tally = repeat_tally + 8'd1;
                if (repeat_tally < repeat_limit)
                    held = 1'b1;
            end
            if (held)
                r.status = STATUS_SUPPRESS;
            else
            begin
                nt = ring_next(tail_ptr);
                if (nt == head_ptr)
                    r.status = STATUS_FULL;
                else
                begin
                    tail_ptr     = nt;
                    key_ring[nt] = cmd;
                    r.status     = STATUS_QUEUED;
                end
                repeat_tally = '0;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ir_result_t want;
        ir_result_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < QUEUE_SLOTS; i++)
                key_ring[i] = '0;
            head_ptr     = QUEUE_SLOTS - 1;
            tail_ptr     = QUEUE_SLOTS - 1;
            repeat_tally = '0;
            expected_sys = SYS_CODE_RESET;
            repeat_limit = THRESHOLD_RESET;
            due_results.delete();
            fail_count   = 0;
            words_due    = 0;
            result_seq   = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SYSTEM_CODE: expected_sys = cfg_data[SYS_W-1:0];
                    CFG_THRESHOLD:   repeat_limit = cfg_data[BYTE_W-1:0];
                    default: ;
                endcase
            end
            // A word is captured before it is executed and its result registered, so a result
            // seen at this edge never belongs to a word accepted at the same edge.
            if (out_valid && out_ready)
            begin
                got.code   = read_code;
                got.valid  = read_valid;
                got.status = event_status;
                if (due_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display(
                            "ircf check: result %0d with none due: %02h/%0b/%0d",
                            result_seq, got.code, got.valid, got.status);
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.code !== want.code || got.valid !== want.valid
                        || got.status !== want.status)
                    begin
                        if (fail_count < 10)
                            $display(
                                "ircf check: result %0d expected %02h/%0b/%0d, got %02h/%0b/%0d",
                                result_seq, want.code, want.valid, want.status,
                                got.code, got.valid, got.status);
                        fail_count++;
                    end
                end
                result_seq++;
            end
            if (in_valid && in_ready)
                due_results.push_back(filter_word(func, system_code, command_byte,
                                                  inverted_command, repeat_flag));
            words_due = due_results.size();
        end
    end

endmodule

// ===== sim/ir_code_filter_fifo_tb.sv =====
// Testbench top for the infrared code filter and queue: drives frames, reads and
// register writes, and gives the verdict. Depends on ircf_pkg, ircf_checker and
// the block ir_code_filter_fifo.
`timescale 1ns / 1ps

module ir_code_filter_fifo_tb;
    import ircf_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  func;
    logic [SYS_W-1:0]      system_code;
    logic [BYTE_W-1:0]     command_byte;
    logic [BYTE_W-1:0]     inverted_command;
    logic                  repeat_flag;
    logic                  out_valid;
    logic                  out_ready;
    logic [BYTE_W-1:0]     read_code;
    logic                  read_valid;
    logic [STATUS_W-1:0]   event_status;

    int fail_count;
    int words_due;
    int sender_gap_pct;
    int receiver_stall_pct;
    logic [SYS_W-1:0] live_sys;

    ir_code_filter_fifo #(.QUEUE_SLOTS(10)) u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .func             (func),
        .system_code      (system_code),
        .command_byte     (command_byte),
        .inverted_command (inverted_command),
        .repeat_flag      (repeat_flag),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .read_code        (read_code),
        .read_valid       (read_valid),
        .event_status     (event_status)
    );

    ircf_checker #(.QUEUE_SLOTS(10)) u_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .func             (func),
        .system_code      (system_code),
        .command_byte     (command_byte),
        .inverted_command (inverted_command),
        .repeat_flag      (repeat_flag),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .read_code        (read_code),
        .read_valid       (read_valid),
        .event_status     (event_status),
        .fail_count       (fail_count),
        .words_due        (words_due)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
        out_ready <= (receiver_stall_pct == 0) || ($urandom_range(99) >= receiver_stall_pct);

    // Presents one word and holds it until the block takes it.
    task automatic send_word(input logic f, input logic [SYS_W-1:0] sys,
                             input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] inv,
                             input logic rep);
        if (sender_gap_pct != 0 && $urandom_range(99) < sender_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < sender_gap_pct)
                @(posedge clk);
        end
        in_valid         <= 1'b1;
        func             <= f;
        system_code      <= sys;
        command_byte     <= cmd;
        inverted_command <= inv;
        repeat_flag      <= rep;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] cmd, input logic rep);
        send_word(FUNC_EVENT, live_sys, cmd, ~cmd, rep);
    endtask

    task automatic send_read();
        send_word(FUNC_READ, 16'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
    endtask

    // Waits until every result word due has been taken from the block.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_due != 0)
            @(posedge clk);
    endtask

    task automatic configure(input logic [SYS_W-1:0] sys, input logic [BYTE_W-1:0] thr);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SYSTEM_CODE;
        cfg_data  <= sys;
        @(posedge clk);
        cfg_index <= CFG_THRESHOLD;
        cfg_data  <= {8'($urandom), thr};
        @(posedge clk);
        cfg_we    <= 1'b0;
        live_sys = sys;
    endtask

    // Reads at read_pct percent, else frames: mostly well-formed with random content, the rest broken.
    task automatic random_words(input int count, input int read_pct);
        logic [SYS_W-1:0]  sys;
        logic [BYTE_W-1:0] cmd;
        logic [BYTE_W-1:0] inv;
        int                pick;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < read_pct)
                send_read();
            else
            begin
                cmd  = 8'($urandom);
                sys  = live_sys;
                inv  = ~cmd;
                pick = $urandom_range(99);
                if (pick < 10)
                    sys = 16'($urandom);
                else if (pick < 18)
                    inv = inv ^ (8'd1 << $urandom_range(7));
                else if (pick < 22)
                    sys = sys ^ (16'd1 << $urandom_range(15));
                send_word(FUNC_EVENT, sys, cmd, inv, $urandom_range(99) < 30);
            end
        end
    endtask

    task automatic run_phase(input logic [SYS_W-1:0] sys, input logic [BYTE_W-1:0] thr,
                             input int gap, input int stall, input int read_pct,
                             input int count);
        settle();
        configure(sys, thr);
        sender_gap_pct     = gap;
        receiver_stall_pct = stall;
        random_words(count, read_pct);
    endtask

    initial
    begin
        #5_000_000;
        $display("ir_code_filter_fifo: mismatch");
        $finish;
    end

    initial
    begin
        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
        live_sys           = SYS_CODE_RESET;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_data         <= '0;
        in_valid         <= 1'b0;
        func             <= FUNC_EVENT;
        system_code      <= '0;
        command_byte     <= '0;
        inverted_command <= '0;
        repeat_flag      <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset register values.
        send_read();
        send_frame(8'h00, 1'b0);
        send_frame(8'hFF, 1'b0);
        send_word(FUNC_EVENT, 16'hFF01, 8'h12, 8'hED, 1'b0);
        send_word(FUNC_EVENT, SYS_CODE_RESET, 8'h12, 8'h12, 1'b0);
        repeat (3) send_frame(8'h5A, 1'b1);
        // A rejected repeat must not advance the repeat count.
        send_word(FUNC_EVENT, 16'h00FF, 8'h5A, 8'hA5, 1'b1);
        send_frame(8'h5A, 1'b1);
        repeat (4) send_read();
        // Fill all usable slots, then one more word is dropped.
        for (int i = 0; i < 10; i++)
            send_frame(8'(8'h11 * i + 8'h01), 1'b0);

        run_phase(16'h0000, 8'd1,   58, 0,  25, 145);
        run_phase(16'hFFFF, 8'd255, 0,  58, 50, 145);
        // A long run of repeats is needed before one gets past the largest threshold.
        for (int i = 0; i < 260; i++)
        begin
            if (i % 40 == 39)
                send_read();
            else
                send_frame(8'($urandom), 1'b1);
        end
        // With a threshold of zero every repeat frame goes through.
        run_phase(16'($urandom), 8'd0, 34, 34, 40, 145);
        run_phase(16'($urandom), 8'($urandom_range(8, 2)), 0, 0, 60, 145);
        run_phase(16'hA55A, 8'd3, 34, 34, 30, 145);
        run_phase(16'($urandom), 8'($urandom_range(255, 1)), 58, 58, 35, 145);

        settle();
        receiver_stall_pct = 34;
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("ir_code_filter_fifo: match");
        else
            $display("ir_code_filter_fifo: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/ircf_pkg.sv
design/ircf_ctrl.sv
design/ircf_datapath.sv
design/ir_code_filter_fifo.sv
sim/ircf_checker.sv
sim/ir_code_filter_fifo_tb.sv
